@@ rtl/tcw_pkg.sv @@
// shared constants and types for the text console writer
// field widths, default geometry, character codes and item kinds
// no dependencies
package tcw_pkg;

  localparam int KindW = 2;
  localparam int CharW = 8;
  localparam int AttrW = 8;
  localparam int PosW  = 11;
  localparam int IdxW  = 11;
  localparam int CellW = CharW + AttrW;

  localparam int ColumnsDef    = 80;
  localparam int RowsDef       = 25;
  localparam int TabAdvanceDef = 5;

  localparam logic [CharW-1:0] ChBs       = 8'h08;
  localparam logic [CharW-1:0] ChTab      = 8'h09;
  localparam logic [CharW-1:0] ChLf       = 8'h0A;
  localparam logic [CharW-1:0] ChCr       = 8'h0D;
  localparam logic [CharW-1:0] ChSpace    = 8'h20;
  localparam logic [CharW-1:0] ChPrintMax = 8'h7F;

  typedef enum logic [KindW-1:0] {
    KIND_PUT  = 2'd0,
    KIND_SET  = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

endpackage

@@ rtl/tcw_in_if.sv @@
// request channel of the text console writer: valid/ready and one item
// depends on tcw_pkg
interface tcw_in_if import tcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [CharW-1:0] char_code;
  logic [AttrW-1:0] attribute;
  logic [PosW-1:0]  position;

  modport source (output valid, output kind, output char_code, output attribute,
                  output position, input ready);
  modport sink (input valid, input kind, input char_code, input attribute,
                input position, output ready);
endinterface

@@ rtl/tcw_out_if.sv @@
// result channel of the text console writer: valid/ready and one result item
// depends on tcw_pkg
interface tcw_out_if import tcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IdxW-1:0]  cursor_pos;
  logic [CharW-1:0] read_char;
  logic [AttrW-1:0] read_attribute;
  logic             scrolled;

  modport source (output valid, output cursor_pos, output read_char,
                  output read_attribute, output scrolled, input ready);
  modport sink (input valid, input cursor_pos, input read_char,
                input read_attribute, input scrolled, output ready);
endinterface

@@ rtl/text_console_writer_top.sv @@
// Text console writer: a COLUMNS x ROWS cell store (character in the low byte,
// attribute in the high byte) held in one synchronous ram, plus a cursor. After
// reset the block sweeps zeros through the ram, one cell a cycle, over every
// cell before it takes its first item. A put that only moves the cursor or
// writes one cell goes from acceptance to the next ready through accept,
// execute and hand-off to the result register; set and read add a step
// after execute, the reciprocal divide step or the ram read. A put that
// scrolls adds a copy and a fill: the ram is copied one cell a cycle up one row
// through its single read and write port, then the bottom row is filled with
// zeros. The result register decouples the output, so a stalled result only
// holds the block when the next result is ready to be delivered.
// depends on tcw_pkg, tcw_in_if, tcw_out_if and tcw_ram
module text_console_writer_top import tcw_pkg::*; #(
  parameter int Columns    = ColumnsDef,
  parameter int Rows       = RowsDef,
  parameter int TabAdvance = TabAdvanceDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_in_if.sink    req_i,
  tcw_out_if.source rsp_o
);

  localparam int Cells      = Columns * Rows;
  localparam int AW         = $clog2(Cells);
  localparam int CW         = $clog2(Columns);
  localparam int RW         = $clog2(Rows);
  localparam int XW         = $clog2(Columns + TabAdvance + 1);
  localparam int RecipShift = PosW + CW;
  localparam int Recip      = ((1 << RecipShift) + Columns - 1) / Columns;
  localparam int RecipW     = $clog2(Recip + 1);
  localparam int ProdW      = PosW + RecipW;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SET,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [KindW-1:0] kind_q, kind_d;
  logic [CharW-1:0] code_q, code_d;
  logic [AttrW-1:0] attr_q, attr_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PosW-1:0]  quot_q, quot_d;
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic [AW-1:0]    sweep_q, sweep_d;
  logic             copy_wr_q, copy_wr_d;
  logic [AW-1:0]    copy_dst_q, copy_dst_d;
  logic [CharW-1:0] res_char_q, res_char_d;
  logic [AttrW-1:0] res_attr_q, res_attr_d;
  logic             scrolled_q, scrolled_d;

  logic             out_valid_q, out_valid_d;
  logic [IdxW-1:0]  out_idx_q, out_idx_d;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic [AttrW-1:0] out_attr_q, out_attr_d;
  logic             out_scr_q, out_scr_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CellW-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [CellW-1:0] mem_rdata;

  logic [AW-1:0]    cur_addr;
  logic [ProdW-1:0] quot_prod;
  logic             pos_in_range;

  assign cur_addr     = AW'(row_q) * AW'(Columns) + AW'(col_q);
  assign quot_prod    = ProdW'(pos_q) * ProdW'(Recip);
  assign pos_in_range = int'(pos_q) < Cells;

  tcw_ram #(
    .Width (CellW),
    .Depth (Cells)
  ) u_cells (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  assign req_i.ready          = (state_q == ST_IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.cursor_pos     = out_idx_q;
  assign rsp_o.read_char      = out_char_q;
  assign rsp_o.read_attribute = out_attr_q;
  assign rsp_o.scrolled       = out_scr_q;

  always_comb begin
    logic [XW-1:0]   col_x;
    logic [PosW-1:0] rem;
    logic            adv;

    state_d     = state_q;
    kind_d      = kind_q;
    code_d      = code_q;
    attr_d      = attr_q;
    pos_d       = pos_q;
    quot_d      = quot_q;
    col_d       = col_q;
    row_d       = row_q;
    sweep_d     = sweep_q;
    copy_wr_d   = (state_q == ST_COPY);
    copy_dst_d  = sweep_q - AW'(Columns);
    res_char_d  = res_char_q;
    res_attr_d  = res_attr_q;
    scrolled_d  = scrolled_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_idx_d   = out_idx_q;
    out_char_d  = out_char_q;
    out_attr_d  = out_attr_q;
    out_scr_d   = out_scr_q;

    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = AW'(pos_q);

    col_x = XW'(col_q);
    rem   = pos_q - PosW'(quot_q * PosW'(Columns));
    adv   = 1'b0;

    // a pending copy write always owns the write port
    if (copy_wr_q) begin
      mem_we    = 1'b1;
      mem_waddr = copy_dst_q;
      mem_wdata = mem_rdata;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        if (sweep_q == AW'(Cells - 1)) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          kind_d     = req_i.kind;
          code_d     = req_i.char_code;
          attr_d     = req_i.attribute;
          pos_d      = req_i.position;
          res_char_d = '0;
          res_attr_d = '0;
          scrolled_d = 1'b0;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_FINISH;
        case (kind_q)
          KIND_PUT: begin
            case (code_q)
              ChCr: col_x = '0;
              ChLf: begin
                col_x = '0;
                adv   = 1'b1;
              end
              ChBs: begin
                if (col_q == '0) begin
                  // back to the end of the previous row if there is one, cell left alone
                  if (row_q != '0) begin
                    col_x = XW'(Columns - 1);
                    row_d = row_q - 1'b1;
                  end
                end else begin
                  col_x     = col_x - 1'b1;
                  mem_we    = 1'b1;
                  mem_waddr = cur_addr - 1'b1;
                  mem_wdata = {attr_q, CharW'(0)};
                end
              end
              ChTab: begin
                if (XW'(Columns) - col_x < XW'(TabAdvance)) begin
                  col_x = XW'(Columns);
                end else begin
                  col_x = col_x + XW'(TabAdvance);
                end
              end
              default: begin
                if (code_q >= ChSpace && code_q <= ChPrintMax) begin
                  mem_we    = 1'b1;
                  mem_waddr = cur_addr;
                  mem_wdata = {attr_q, code_q};
                  col_x     = col_x + 1'b1;
                end
              end
            endcase
            if (col_x >= XW'(Columns)) begin
              col_x = '0;
              adv   = 1'b1;
            end
            col_d = col_x[CW-1:0];
            if (adv) begin
              if (row_q == RW'(Rows - 1)) begin
                scrolled_d = 1'b1;
                sweep_d    = AW'(Columns);
                state_d    = ST_COPY;
              end else begin
                row_d = row_q + 1'b1;
              end
            end
          end
          KIND_SET: begin
            // quotient by reciprocal, exact for every 11-bit position
            quot_d  = PosW'(quot_prod >> RecipShift);
            state_d = ST_SET;
          end
          KIND_READ: begin
            if (pos_in_range) begin
              mem_re  = 1'b1;
              state_d = ST_READ;
            end
          end
          default: ;
        endcase
      end
      ST_SET: begin
        col_d   = rem[CW-1:0];
        row_d   = (quot_q >= PosW'(Rows)) ? RW'(Rows - 1) : quot_q[RW-1:0];
        state_d = ST_FINISH;
      end
      ST_READ: begin
        res_char_d = mem_rdata[CharW-1:0];
        res_attr_d = mem_rdata[CellW-1:CharW];
        state_d    = ST_FINISH;
      end
      ST_COPY: begin
        mem_re    = 1'b1;
        mem_raddr = sweep_q;
        if (sweep_q == AW'(Cells - 1)) begin
          sweep_d = AW'(Cells - Columns);
          state_d = ST_FILL;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_FILL: begin
        // wait for the last copy write before zeroing the bottom row
        if (!copy_wr_q) begin
          mem_we    = 1'b1;
          mem_waddr = sweep_q;
          mem_wdata = '0;
          if (sweep_q == AW'(Cells - 1)) begin
            state_d = ST_FINISH;
          end else begin
            sweep_d = sweep_q + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_idx_d   = IdxW'(cur_addr);
          out_char_d  = res_char_q;
          out_attr_d  = res_attr_q;
          out_scr_d   = scrolled_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      kind_q      <= '0;
      code_q      <= '0;
      attr_q      <= '0;
      pos_q       <= '0;
      quot_q      <= '0;
      col_q       <= '0;
      row_q       <= '0;
      sweep_q     <= '0;
      copy_wr_q   <= 1'b0;
      copy_dst_q  <= '0;
      res_char_q  <= '0;
      res_attr_q  <= '0;
      scrolled_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_char_q  <= '0;
      out_attr_q  <= '0;
      out_scr_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      code_q      <= code_d;
      attr_q      <= attr_d;
      pos_q       <= pos_d;
      quot_q      <= quot_d;
      col_q       <= col_d;
      row_q       <= row_d;
      sweep_q     <= sweep_d;
      copy_wr_q   <= copy_wr_d;
      copy_dst_q  <= copy_dst_d;
      res_char_q  <= res_char_d;
      res_attr_q  <= res_attr_d;
      scrolled_q  <= scrolled_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_char_q  <= out_char_d;
      out_attr_q  <= out_attr_d;
      out_scr_q   <= out_scr_d;
    end
  end

  // cursor never rests outside the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(col_q) < Columns) && (int'(row_q) < Rows))
    else $error("cursor outside the screen");

  // scroll copy writes always land above the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_wr_q |-> (int'(copy_dst_q) < Cells - Columns))
    else $error("scroll copy write into bottom row");

  // a read and a write of the same cell never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("ram read and write collide");

  // with the result register free, a finished item reaches it next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished item not handed to result register");

  // no item is taken while the cell store is being swept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY || state_q == ST_FILL || state_q == ST_CLEAR) |=> !$rose(req_i.ready)
      || (state_q == ST_IDLE))
    else $error("input opened in the middle of a sweep");

endmodule

@@ rtl/tcw_ram.sv @@
// generic simple dual-port ram: one write port, one read port, registered read
// depends on tcw_pkg for default sizes
module tcw_ram import tcw_pkg::*; #(
  parameter int Width = CellW,
  parameter int Depth = ColumnsDef * RowsDef,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
